// ===== hw/rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and types for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Arithmetic word width; the ports stay 64 bits and use the low bits only.
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned PORT_BITS = 64;
  localparam int unsigned CNT_W     = $clog2(WORD_BITS);
  // Working width of the modular step: holds 2r + a < 3m plus a sign bit.
  localparam int unsigned EXT_W     = WORD_BITS + 2;

  typedef logic [WORD_BITS-1:0] word_t;

  // Status of the shared modular multiplier seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_MUL    = 5'b00100,
    S_SQR    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

endpackage

// ===== hw/rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// power = base ^ exponent mod modulus, right-to-left square and multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries base_i and exponent_i; the
//   output channel (out_valid_o/out_ready_i) returns power_o, one result per
//   transaction, in order. The modulus is to be written through cfg_we_i and
//   cfg_wdata_i only while the block is idle (not enforced); it resets to 1.
// Operation:
//   All arithmetic runs through one bit-serial modular multiplier. An item
//   costs one reduction of the base, one squaring per exponent bit below the
//   top set bit and one multiply per set bit; exponent 0 costs the reduction
//   only. A modulus of 0 or 1 returns 0 without a product, and in_ready_o
//   is high only while the sequencer is idle.
// Reset and stall:
//   Reset clears the sequencer and the output valid flag. A finished result
//   sits in the output register while the next transaction is accepted; a
//   further result waits in the sequencer until that register is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mexp_pkg::PORT_BITS-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mexp_pkg::PORT_BITS-1:0]  base_i,
  input  logic [mexp_pkg::PORT_BITS-1:0]  exponent_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mexp_pkg::PORT_BITS-1:0]  power_o
);

  mexp_pkg::state_e state_q, state_d;
  mexp_pkg::word_t  modulus_q;
  mexp_pkg::word_t  e_q, e_d;
  mexp_pkg::word_t  b_q, b_d;
  mexp_pkg::word_t  acc_q, acc_d;
  mexp_pkg::word_t  power_q, power_d;
  logic             out_valid_q, out_valid_d;

  logic                 mm_start;
  mexp_pkg::word_t      mm_a, mm_b, mm_r;
  mexp_pkg::mm_status_t mm_status;

  mexp_pkg::word_t e_shift;
  logic            m_trivial;
  logic            out_free;

  assign m_trivial = (modulus_q[mexp_pkg::WORD_BITS-1:1] == '0);
  assign e_shift   = e_q >> 1;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    e_d         = e_q;
    b_d         = b_q;
    acc_d       = acc_q;
    power_d     = power_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mm_start    = 1'b0;
    mm_a        = b_q;
    mm_b        = b_q;

    unique case (state_q)
      mexp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          e_d = exponent_i[mexp_pkg::WORD_BITS-1:0];
          if (m_trivial) begin
            acc_d   = '0;
            state_d = mexp_pkg::S_DONE;
          end else begin
            // base mod m computed as 1 * base mod m
            acc_d    = mexp_pkg::WORD_BITS'(1);
            mm_start = 1'b1;
            mm_a     = mexp_pkg::WORD_BITS'(1);
            mm_b     = base_i[mexp_pkg::WORD_BITS-1:0];
            state_d  = mexp_pkg::S_REDUCE;
          end
        end
      end
      mexp_pkg::S_REDUCE: begin
        if (mm_status.done) begin
          b_d = mm_r;
          if (e_q == '0) begin
            state_d = mexp_pkg::S_DONE;
          end else if (e_q[0]) begin
            mm_start = 1'b1;
            mm_a     = acc_q;
            mm_b     = mm_r;
            state_d  = mexp_pkg::S_MUL;
          end else begin
            mm_start = 1'b1;
            mm_a     = mm_r;
            mm_b     = mm_r;
            state_d  = mexp_pkg::S_SQR;
          end
        end
      end
      mexp_pkg::S_MUL: begin
        if (mm_status.done) begin
          acc_d = mm_r;
          // no higher exponent bits: the remaining squarings are unused
          if (e_shift == '0) begin
            state_d = mexp_pkg::S_DONE;
          end else begin
            mm_start = 1'b1;
            state_d  = mexp_pkg::S_SQR;
          end
        end
      end
      mexp_pkg::S_SQR: begin
        if (mm_status.done) begin
          b_d = mm_r;
          e_d = e_shift;
          if (e_shift == '0) begin
            state_d = mexp_pkg::S_DONE;
          end else if (e_shift[0]) begin
            mm_start = 1'b1;
            mm_a     = acc_q;
            mm_b     = mm_r;
            state_d  = mexp_pkg::S_MUL;
          end else begin
            mm_start = 1'b1;
            mm_a     = mm_r;
            mm_b     = mm_r;
            state_d  = mexp_pkg::S_SQR;
          end
        end
      end
      mexp_pkg::S_DONE: begin
        if (out_free) begin
          power_d     = acc_q;
          out_valid_d = 1'b1;
          state_d     = mexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mexp_pkg::S_IDLE;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .a_i      (mm_a),
    .b_i      (mm_b),
    .m_i      (modulus_q),
    .status_o (mm_status),
    .r_o      (mm_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= mexp_pkg::WORD_BITS'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i[mexp_pkg::WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q     <= e_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    power_q <= power_d;
  end

  assign in_ready_o  = (state_q == mexp_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign power_o     = mexp_pkg::PORT_BITS'(power_q);

  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("mexp: state not one-hot");

  a_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_start |-> (!mm_status.busy))
    else $error("mexp: multiplier started while busy");

  a_done_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_status.done |-> (state_q == mexp_pkg::S_REDUCE || state_q == mexp_pkg::S_MUL ||
                        state_q == mexp_pkg::S_SQR))
    else $error("mexp: multiplier done outside a product state");

  a_acc_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mexp_pkg::S_MUL || state_q == mexp_pkg::S_SQR) |-> (acc_q < modulus_q))
    else $error("mexp: accumulator not below modulus");

  a_busy_in_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_status.busy |-> !in_ready_o)
    else $error("mexp: ready while multiplier busy");

endmodule

// ===== hw/rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle,
// MSB first, with a doubling, an add and a bounded reduction each step.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  mexp_pkg::word_t       a_i,
  input  mexp_pkg::word_t       b_i,
  input  mexp_pkg::word_t       m_i,
  output mexp_pkg::mm_status_t  status_o,
  output mexp_pkg::word_t       r_o
);

  mexp_pkg::word_t r_q, r_d;
  mexp_pkg::word_t a_q, a_d;
  mexp_pkg::word_t bits_q, bits_d;
  logic [mexp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;

  logic [mexp_pkg::EXT_W-1:0] t_sum, t_m1, t_m2, m_ext;
  mexp_pkg::word_t step_r;

  // t = 2r + (bit ? a : 0) < 3m; subtract m or 2m, pick the one in [0, m)
  always_comb begin
    m_ext = mexp_pkg::EXT_W'(m_i);
    t_sum = {1'b0, r_q, 1'b0}
          + (bits_q[mexp_pkg::WORD_BITS-1] ? mexp_pkg::EXT_W'(a_q) : '0);
    t_m1  = t_sum - m_ext;
    t_m2  = t_sum - {m_ext[mexp_pkg::EXT_W-2:0], 1'b0};
    priority if (!t_m2[mexp_pkg::EXT_W-1]) begin
      step_r = t_m2[mexp_pkg::WORD_BITS-1:0];
    end else if (!t_m1[mexp_pkg::EXT_W-1]) begin
      step_r = t_m1[mexp_pkg::WORD_BITS-1:0];
    end else begin
      step_r = t_sum[mexp_pkg::WORD_BITS-1:0];
    end
  end

  always_comb begin
    r_d    = r_q;
    a_d    = a_q;
    bits_d = bits_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d    = '0;
      a_d    = a_i;
      bits_d = b_i;
      cnt_d  = mexp_pkg::CNT_W'(mexp_pkg::WORD_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d    = step_r;
      bits_d = bits_q << 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    a_q    <= a_d;
    bits_q <= bits_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign r_o           = r_q;

  // Partial remainder stays reduced throughout the product.
  a_r_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (r_q < m_i))
    else $error("mulmod: partial remainder not below modulus");

  a_a_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (a_q < m_i))
    else $error("mulmod: multiplicand not below modulus");

  a_done_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == '0) |=> (done_q && !busy_q))
    else $error("mulmod: missing done after last bit");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the modular exponentiation block.
// A queue-fed driver sends base/exponent transactions in random bursts, a
// monitor checks every power result against an in-order store of predicted
// values, and the modulus is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_BITS     = mexp_pkg::WORD_BITS;
  localparam int unsigned PORT_BITS     = mexp_pkg::PORT_BITS;
  localparam int unsigned IDLE_LIMIT    = 60000;  // cycles with no transaction
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 200;
  localparam logic [PORT_BITS-1:0] PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;

  typedef mexp_pkg::word_t word_t;
  typedef logic [PORT_BITS-1:0] port_t;

  typedef struct {
    port_t base;
    port_t exponent;
  } operands_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN,
    RDY_HOLD
  } rdy_mode_e;

  logic  clk_i     = 1'b0;
  logic  rst_ni    = 1'b0;
  logic  cfg_we    = 1'b0;
  port_t cfg_wdata = '0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  port_t base      = '0;
  port_t exponent  = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  port_t power;

  operands_t   operand_queue[$];
  word_t       power_queue[$];
  word_t       modulus_q = word_t'(1);
  int unsigned errors    = 0;

  modular_exponentiation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .base_i      (base),
    .exponent_i  (exponent),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .power_o     (power)
  );

  initial forever #6 clk_i = ~clk_i;

  // base^exp mod m, right-to-left, full double-width products
  function automatic word_t mod_power(word_t m, word_t b_in, word_t e_in);
    logic [2*WORD_BITS-1:0] prod;
    logic [2*WORD_BITS-1:0] wide_m;
    word_t                  acc;
    word_t                  sq;
    if (m <= word_t'(1)) return '0;
    wide_m = {{WORD_BITS{1'b0}}, m};
    sq     = b_in % m;
    acc    = word_t'(1);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (e_in[i]) begin
        prod = {{WORD_BITS{1'b0}}, acc} * {{WORD_BITS{1'b0}}, sq};
        acc  = word_t'(prod % wide_m);
      end
      prod = {{WORD_BITS{1'b0}}, sq} * {{WORD_BITS{1'b0}}, sq};
      sq   = word_t'(prod % wide_m);
    end
    return acc;
  endfunction

  function automatic port_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic port_t rand_base();
    case ($urandom_range(0, 5))
      0:       return port_t'(modulus_q) - 1;
      1:       return port_t'(modulus_q);
      2:       return port_t'($urandom_range(0, 3));
      default: return rand64();
    endcase
  endfunction

  // mostly short exponents to keep the run short, some full width
  function automatic port_t rand_exponent();
    if ($urandom_range(0, 4) == 0) return rand64();
    return rand64() >> $urandom_range(44, 64);
  endfunction

  task automatic add_item(port_t b, port_t e);
    operands_t op;
    op.base     = b;
    op.exponent = e;
    operand_queue.push_back(op);
  endtask

  // Wait until every queued transaction went through and every result came
  // back. Sampled on the falling edge so all rising-edge updates have landed.
  task automatic drain();
    do @(negedge clk_i);
    while (operand_queue.size() != 0 || in_valid || power_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_modulus(port_t value);
    drain();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    modulus_q  = value[WORD_BITS-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Driver: bursts of transactions separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    operands_t op;
    logic      next_valid;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        power_queue.push_back(mod_power(modulus_q, base[WORD_BITS-1:0],
                                        exponent[WORD_BITS-1:0]));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (operand_queue.size() != 0) begin
          op         = operand_queue.pop_front();
          base      <= op.base;
          exponent  <= op.exponent;
          next_valid = 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 7);
            // long gaps land anywhere inside a computation, short ones near idle
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                   : $urandom_range(0, 3);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: ready follows a mode that changes every so often.
  rdy_mode_e   rdy_mode   = RDY_ALWAYS;
  int unsigned stall_left = 0;
  logic [7:0]  stall_pat  = '0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        rdy_mode   = rdy_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(1, 300);
        stall_pat  = 8'($urandom);
      end else begin
        stall_left--;
      end
      case (rdy_mode)
        RDY_ALWAYS:  out_ready <= 1'b1;
        RDY_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
        RDY_PATTERN: out_ready <= stall_pat[stall_left[2:0]];
        default:     out_ready <= (stall_left < 8);
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (power_queue.size() == 0) begin
        $error("unexpected transaction: power actual %h", power);
        errors++;
      end else begin
        want = power_queue.pop_front();
        if (power !== port_t'(want)) begin
          $error("power mismatch: expected %h, actual %h", want, power);
          errors++;
        end
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    port_t m;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // modulus still at its reset value of one
    add_item(rand64(), '0);
    add_item('1, '1);

    set_modulus('1);
    add_item('0, '0);
    add_item('0, 5);
    add_item('1, 3);
    add_item('1, '0);
    add_item('1 - 1, '1);
    add_item(2, 63);
    add_item(1, '1);
    add_item(rand64(), 1);

    set_modulus(PRIME_64);
    add_item(PRIME_64 - 1, 2);
    add_item(PRIME_64, 7);
    add_item(PRIME_64 + 1, '1);
    add_item(rand64(), rand64());

    set_modulus(2);
    add_item(rand64() | 1, rand64());
    add_item(rand64() & ~port_t'(1), rand64() | 1);

    set_modulus(1);
    add_item(rand64(), rand64());
    add_item('1, '0);

    // Each phase starts only after the previous one drained completely.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       m = rand64() | {1'b1, {(PORT_BITS-1){1'b0}}};
        1:       m = port_t'($urandom_range(3, 1000));
        2:       m = {32'h0, $urandom};
        3:       m = '1;
        default: m = rand64() >> $urandom_range(0, 62);
      endcase
      if (m < 2) m = 2;
      set_modulus(m);
      repeat (20) add_item(rand_base(), rand_exponent());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && power_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
